// ===== sv/awb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package awb_pkg;

	localparam int PROD_W = 40;  // 32b signed coefficient times 8b signed coordinate
	localparam int SUM_W  = 42;  // two products plus offset
	localparam int SX_W   = SUM_W - 8;  // source coordinate, 8 fraction bits
	localparam int W_W    = 17;  // bilinear weight product, up to 65536
	localparam int ACC_W  = 25;

	typedef enum logic [2:0] {
		REG_COEF_XX  = 3'd0,
		REG_COEF_XY  = 3'd1,
		REG_OFFSET_X = 3'd2,
		REG_COEF_YX  = 3'd3,
		REG_COEF_YY  = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_SIZE     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [31:0] coef_xx;
		logic signed [31:0] coef_xy;
		logic signed [31:0] offset_x;
		logic signed [31:0] coef_yx;
		logic signed [31:0] coef_yy;
		logic signed [31:0] offset_y;
		logic [7:0]         size;  // effective size, already capped
	} cfg_t;

	typedef struct packed {
		logic                   valid;
		logic                   store;
		logic                   ok;  // sample passed the destination range check
		logic [6:0]             row;
		logic [6:0]             col;
		logic [7:0]             pixel;
		logic signed [SX_W-1:0] sx;
		logic signed [SX_W-1:0] sy;
	} map_t;

	typedef struct packed {
		logic       valid;
		logic       in_img;
		logic [7:0] fx;
		logic [7:0] fy;
		logic       x0_par;
		logic       x1_par;
		logic       y0_par;
		logic       y1_par;
	} tap_t;

endpackage
`default_nettype wire

// ===== sv/awb_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface awb_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [6:0] row;
	logic [6:0] col;
	logic [7:0] pixel_in;

	modport source(output valid, output cmd, output row, output col, output pixel_in,
		input ready);
	modport sink(input valid, input cmd, input row, input col, input pixel_in,
		output ready);
endinterface
`default_nettype wire

// ===== sv/awb_res_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
interface awb_res_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_out;
	logic       inside_res;

	modport source(output valid, output pixel_out, output inside_res, input ready);
	modport sink(input valid, input pixel_out, input inside_res, output ready);
endinterface
`default_nettype wire

// ===== sv/affine_warp_bilinear_sampler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Affine warp with bilinear sampling of a square 8-bit source image.
//
// req channel: cmd 0 stores pixel_in at (row, col) of the source image; cmd 1
// samples destination (row, col): it is mapped through the Q16.16 affine
// registers to a source position with 8 fraction bits and the four neighbors
// are blended. Only samples produce a result on res (pixel_out, inside_res).
// Configuration goes through cfg_we / cfg_idx / cfg_data, only while idle.
//
// Throughput: one request per cycle while res is not stalled, stores and samples mixed freely.
// Pipeline: six register stages (3 map stages, memory read, weight/select
// stage, blend/output register). The four neighbor reads come from four parity
// banks (row and column parity), one read port each.
// Stores write the banks in the same stage where samples read them, so
// request order is kept exactly.
//
// Reset clears pipeline valids and loads the default registers (identity
// matrix, size 112). Image contents are undefined until written.
// A stall on res with a result waiting freezes the whole pipeline; req.ready drops in that cycle.
module affine_warp_bilinear_sampler #(
	parameter int MAX_SIZE = 128
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	awb_req_if.sink          req,
	awb_res_if.source        res,
	input  wire logic        cfg_we,
	input  wire logic [2:0]  cfg_idx,
	input  wire logic [31:0] cfg_data
);
	import awb_pkg::*;

	localparam int AW = $clog2(MAX_SIZE);      // coordinate bits
	localparam int BW = (AW > 1) ? AW - 1 : 1;  // coordinate bits in a bank, parity bit dropped

	// configuration registers
	logic signed [31:0] coef_xx_q, coef_xy_q, offset_x_q;
	logic signed [31:0] coef_yx_q, coef_yy_q, offset_y_q;
	logic [7:0]         size_q;
	logic [7:0]         size_eff;
	cfg_t               cfg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_xx_q  <= 32'sd65536;
			coef_xy_q  <= '0;
			offset_x_q <= '0;
			coef_yx_q  <= '0;
			coef_yy_q  <= 32'sd65536;
			offset_y_q <= '0;
			size_q     <= 8'd112;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_COEF_XX:  coef_xx_q  <= cfg_data;
				REG_COEF_XY:  coef_xy_q  <= cfg_data;
				REG_OFFSET_X: offset_x_q <= cfg_data;
				REG_COEF_YX:  coef_yx_q  <= cfg_data;
				REG_COEF_YY:  coef_yy_q  <= cfg_data;
				REG_OFFSET_Y: offset_y_q <= cfg_data;
				REG_SIZE:     size_q     <= cfg_data[7:0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	// size saturates at the image store depth
	assign size_eff = ({24'd0, size_q} > MAX_SIZE) ? 8'(MAX_SIZE) : size_q;

	always_comb begin
		cfg.coef_xx  = coef_xx_q;
		cfg.coef_xy  = coef_xy_q;
		cfg.offset_x = offset_x_q;
		cfg.coef_yx  = coef_yx_q;
		cfg.coef_yy  = coef_yy_q;
		cfg.offset_y = offset_y_q;
		cfg.size     = size_eff;
	end

	// global advance: the output register is free or being drained
	logic en;
	logic out_valid;
	assign en        = !out_valid || res.ready;
	assign req.ready = en;

	map_t map;

	awb_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.cfg     (cfg),
		.in_valid(req.valid),
		.in_cmd  (req.cmd),
		.in_row  (req.row),
		.in_col  (req.col),
		.in_pixel(req.pixel_in),
		.map     (map)
	);

	// stage 4: range check, neighbor addresses, bank access
	logic [SX_W-9:0]   px_w, py_w;
	logic              src_in;
	logic [AW-1:0]     px, py, px1, py1;
	logic              clamp_x, clamp_y;
	logic [AW-1:0]     ya [2];
	logic [AW-1:0]     xa [2];
	logic [AW:0]       ya_ext [2];
	logic [AW:0]       xa_ext [2];
	logic [AW+6:0]     st_row_ext, st_col_ext;
	logic [AW:0]       st_row, st_col;
	logic              st_we;

	assign px_w = map.sx[SX_W-1:8];
	assign py_w = map.sy[SX_W-1:8];
	assign src_in = map.ok && !map.sx[SX_W-1] && !map.sy[SX_W-1]
		&& (px_w < (SX_W-8)'(size_eff)) && (py_w < (SX_W-8)'(size_eff));
	assign px = px_w[AW-1:0];
	assign py = py_w[AW-1:0];
	// last column or row: right or lower neighbor clamps to the edge
	assign clamp_x = (px_w[7:0] == size_eff - 8'd1);
	assign clamp_y = (py_w[7:0] == size_eff - 8'd1);
	assign px1 = clamp_x ? px : px + AW'(1);
	assign py1 = clamp_y ? py : py + AW'(1);

	// each parity bank takes whichever neighbor coordinate has its parity
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			ya[i] = (py[0] == i[0]) ? py : py1;
			xa[i] = (px[0] == i[0]) ? px : px1;
			ya_ext[i] = {1'b0, ya[i]};
			xa_ext[i] = {1'b0, xa[i]};
		end
	end

	assign st_row_ext = {AW'(0), map.row};
	assign st_col_ext = {AW'(0), map.col};
	assign st_row = {1'b0, st_row_ext[AW-1:0]};
	assign st_col = {1'b0, st_col_ext[AW-1:0]};
	assign st_we = en && map.valid && map.store
		&& ({25'd0, map.row} < MAX_SIZE) && ({25'd0, map.col} < MAX_SIZE);

	logic [3:0][7:0] bank_data;

	for (genvar g = 0; g < 4; g++) begin : g_bank
		logic we_b;
		assign we_b = st_we && (st_row[0] == g[1]) && (st_col[0] == g[0]);
		awb_bank #(.ADDR_W(2 * BW)) u_bank (
			.clk  (clk),
			.we   (we_b),
			.waddr({st_row[BW:1], st_col[BW:1]}),
			.wdata(map.pixel),
			.re   (en),
			.raddr({ya_ext[g / 2][BW:1], xa_ext[g % 2][BW:1]}),
			.rdata(bank_data[g])
		);
	end

	// stage 4 registers ride alongside the bank read data
	logic       v_s4, inside_s4;
	logic [7:0] fx_s4, fy_s4;
	logic       x0p_s4, x1p_s4, y0p_s4, y1p_s4;
	tap_t       tap;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= map.valid && !map.store;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			inside_s4 <= src_in;
			fx_s4     <= map.sx[7:0];
			fy_s4     <= map.sy[7:0];
			x0p_s4    <= px[0];
			x1p_s4    <= px1[0];
			y0p_s4    <= py[0];
			y1p_s4    <= py1[0];
		end
	end

	always_comb begin
		tap.valid  = v_s4;
		tap.in_img = inside_s4;
		tap.fx     = fx_s4;
		tap.fy     = fy_s4;
		tap.x0_par = x0p_s4;
		tap.x1_par = x1p_s4;
		tap.y0_par = y0p_s4;
		tap.y1_par = y1p_s4;
	end

	awb_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.tap       (tap),
		.bank_data (bank_data),
		.out_valid (out_valid),
		.out_pixel (res.pixel_out),
		.out_inside(res.inside_res)
	);

	assign res.valid = out_valid;

	// outside samples always read as zero
	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.inside_res |-> res.pixel_out == 8'd0)
		else $error("outside sample with nonzero pixel");

	// an inside hit needs a nonempty image
	a_inside_size: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.inside_res |-> size_eff != 8'd0)
		else $error("inside sample with zero image size");

	// ready only drops while a result waits on a stalled receiver
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> out_valid && !res.ready)
		else $error("request stalled without output backpressure");
endmodule
`default_nettype wire

// ===== sv/awb_map.sv =====
`timescale 1ns / 1ps
`default_nettype none
module awb_map (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire awb_pkg::cfg_t cfg,
	input  wire logic         in_valid,
	input  wire logic         in_cmd,
	input  wire logic [6:0]   in_row,
	input  wire logic [6:0]   in_col,
	input  wire logic [7:0]   in_pixel,
	output awb_pkg::map_t     map
);
	import awb_pkg::*;

	// stage 1: products
	logic                    v_s1, store_s1, ok_s1;
	logic [6:0]              row_s1, col_s1;
	logic [7:0]              pix_s1;
	logic signed [PROD_W-1:0] pxc_s1, pxr_s1, pyc_s1, pyr_s1;
	// stage 2: sums
	logic                    v_s2, store_s2, ok_s2;
	logic [6:0]              row_s2, col_s2;
	logic [7:0]              pix_s2;
	logic signed [SUM_W-1:0] sumx_s2, sumy_s2;
	// stage 3: truncated source position
	logic                    v_s3, store_s3, ok_s3;
	logic [6:0]              row_s3, col_s3;
	logic [7:0]              pix_s3;
	logic signed [SX_W-1:0]  sx_s3, sy_s3;

	logic signed [7:0]       col_sg, row_sg;
	logic signed [PROD_W-1:0] pxc, pxr, pyc, pyr;
	logic                    ok_in;
	logic signed [SUM_W-1:0] bx, by;

	assign col_sg = $signed({1'b0, in_col});
	assign row_sg = $signed({1'b0, in_row});
	assign pxc = cfg.coef_xx * col_sg;
	assign pxr = cfg.coef_xy * row_sg;
	assign pyc = cfg.coef_yx * col_sg;
	assign pyr = cfg.coef_yy * row_sg;
	assign ok_in = (cfg.size != 8'd0) && ({1'b0, in_row} < cfg.size)
		&& ({1'b0, in_col} < cfg.size);

	// divide by 256 toward zero: bias negatives by 255 before the shift
	assign bx = sumx_s2 + (sumx_s2[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));
	assign by = sumy_s2 + (sumy_s2[SUM_W-1] ? SUM_W'(255) : SUM_W'(0));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			store_s1 <= !in_cmd;
			ok_s1    <= ok_in;
			row_s1   <= in_row;
			col_s1   <= in_col;
			pix_s1   <= in_pixel;
			pxc_s1   <= pxc;
			pxr_s1   <= pxr;
			pyc_s1   <= pyc;
			pyr_s1   <= pyr;

			store_s2 <= store_s1;
			ok_s2    <= ok_s1;
			row_s2   <= row_s1;
			col_s2   <= col_s1;
			pix_s2   <= pix_s1;
			sumx_s2  <= SUM_W'(pxc_s1) + SUM_W'(pxr_s1) + SUM_W'(cfg.offset_x);
			sumy_s2  <= SUM_W'(pyc_s1) + SUM_W'(pyr_s1) + SUM_W'(cfg.offset_y);

			store_s3 <= store_s2;
			ok_s3    <= ok_s2;
			row_s3   <= row_s2;
			col_s3   <= col_s2;
			pix_s3   <= pix_s2;
			sx_s3    <= bx[SUM_W-1:8];
			sy_s3    <= by[SUM_W-1:8];
		end
	end

	always_comb begin
		map.valid = v_s3;
		map.store = store_s3;
		map.ok    = ok_s3;
		map.row   = row_s3;
		map.col   = col_s3;
		map.pixel = pix_s3;
		map.sx    = sx_s3;
		map.sy    = sy_s3;
	end
endmodule
`default_nettype wire

// ===== sv/awb_bank.sv =====
`timescale 1ns / 1ps
`default_nettype none
module awb_bank #(
	parameter int ADDR_W = 12
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [7:0]        wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic [7:0]             rdata
);
	logic [7:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== sv/awb_blend.sv =====
`timescale 1ns / 1ps
`default_nettype none
module awb_blend (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           en,
	input  wire awb_pkg::tap_t  tap,
	input  wire logic [3:0][7:0] bank_data,  // index {y parity, x parity}
	output logic                out_valid,
	output logic [7:0]          out_pixel,
	output logic                out_inside
);
	import awb_pkg::*;

	logic             v_s5, in_s5;
	logic [W_W-1:0]   w00_s5, w10_s5, w01_s5, w11_s5;
	logic [7:0]       p00_s5, p10_s5, p01_s5, p11_s5;
	logic             v_s6, in_s6;
	logic [7:0]       pix_s6;

	logic [8:0]       wx0, wy0, wx1, wy1;
	logic [ACC_W-1:0] acc;

	assign wx0 = 9'd256 - {1'b0, tap.fx};
	assign wy0 = 9'd256 - {1'b0, tap.fy};
	assign wx1 = {1'b0, tap.fx};
	assign wy1 = {1'b0, tap.fy};

	assign acc = ACC_W'(w00_s5 * p00_s5) + ACC_W'(w10_s5 * p10_s5)
		+ ACC_W'(w01_s5 * p01_s5) + ACC_W'(w11_s5 * p11_s5);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s5 <= tap.valid;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			in_s5  <= tap.in_img;
			w00_s5 <= W_W'(wx0 * wy0);
			w10_s5 <= W_W'(wx1 * wy0);
			w01_s5 <= W_W'(wx0 * wy1);
			w11_s5 <= W_W'(wx1 * wy1);
			p00_s5 <= bank_data[{tap.y0_par, tap.x0_par}];
			p10_s5 <= bank_data[{tap.y0_par, tap.x1_par}];
			p01_s5 <= bank_data[{tap.y1_par, tap.x0_par}];
			p11_s5 <= bank_data[{tap.y1_par, tap.x1_par}];

			in_s6  <= in_s5;
			pix_s6 <= in_s5 ? acc[23:16] : 8'd0;
		end
	end

	assign out_valid  = v_s6;
	assign out_pixel  = pix_s6;
	assign out_inside = in_s6;
endmodule
`default_nettype wire

// ===== verif/tb_affine_warp_bilinear_sampler.sv =====
`timescale 1ns / 1ps
module tb_affine_warp_bilinear_sampler;
	import awb_pkg::*;

	localparam int IMG = 128;
	localparam logic [2:0] REG_UNUSED = 3'd7;  // index past the last register
	localparam bit CMD_STORE = 1'b0;
	localparam bit CMD_SAMPLE = 1'b1;
	localparam int DRAIN_CYCLES = 12;  // pipeline is 6 deep; stores give no result

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [31:0] cfg_data;

	awb_req_if req ();
	awb_res_if res ();

	affine_warp_bilinear_sampler dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.res(res),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// Run limit, far beyond the slowest legal run.
	initial begin
		#30_000_000;
		$display("simulation failed");
		$finish;
	end

	// Shadow of the block: registers and source image, plus a map of the
	// pixels written so far so a sample never reads an undefined pixel.
	logic signed [31:0] mat[6];
	logic [7:0] size_reg;
	logic [7:0] image[IMG*IMG];
	bit written[IMG*IMG];

	typedef struct {
		logic [7:0] pixel;
		logic in_img;
	} pix_res_t;

	typedef struct {
		bit in_img;
		int px, py, px1, py1, fx, fy;
	} src_pos_t;

	pix_res_t pending_pixels[$];

	int n_errors, n_mismatch, n_samples, n_stores, n_outside, n_phases;
	bit calm;  // no idling on either side

	function automatic int eff_size();
		return (size_reg > IMG) ? IMG : int'(size_reg);
	endfunction

	// Destination position to source neighbors, truncating the Q.8 position
	// toward zero.
	function automatic src_pos_t map_dest(input logic [6:0] row, input logic [6:0] col);
		src_pos_t p;
		longint sx, sy;
		int sz;
		sz = eff_size();
		p = '{default: 0};
		if (sz == 0 || row >= sz || col >= sz)
			return p;
		sx = (longint'(mat[REG_COEF_XX]) * longint'(col) + longint'(mat[REG_COEF_XY]) *
			longint'(row) + longint'(mat[REG_OFFSET_X])) / 256;
		sy = (longint'(mat[REG_COEF_YX]) * longint'(col) + longint'(mat[REG_COEF_YY]) *
			longint'(row) + longint'(mat[REG_OFFSET_Y])) / 256;
		if (sx < 0 || sy < 0)
			return p;
		if ((sx >> 8) > sz - 1 || (sy >> 8) > sz - 1)
			return p;
		p.in_img = 1'b1;
		p.fx = int'(sx & 255);
		p.fy = int'(sy & 255);
		p.px = int'(sx >> 8);
		p.py = int'(sy >> 8);
		// right and lower neighbors clamp at the last column and row
		p.px1 = (p.px + 1 < sz) ? p.px + 1 : p.px;
		p.py1 = (p.py + 1 < sz) ? p.py + 1 : p.py;
		return p;
	endfunction

	function automatic pix_res_t blend_sample(input logic [6:0] row, input logic [6:0] col);
		pix_res_t r;
		src_pos_t p;
		int unsigned acc;
		p = map_dest(row, col);
		r = '{pixel: 8'd0, in_img: 1'b0};
		if (!p.in_img)
			return r;
		acc = (256 - p.fx) * (256 - p.fy) * image[p.py*IMG + p.px]
			+ p.fx * (256 - p.fy) * image[p.py*IMG + p.px1]
			+ (256 - p.fx) * p.fy * image[p.py1*IMG + p.px]
			+ p.fx * p.fy * image[p.py1*IMG + p.px1];
		r.pixel = 8'((acc >> 16) & 32'hFF);
		r.in_img = 1'b1;
		return r;
	endfunction

	// Drive one request and wait for it to be taken; the shadow is updated at
	// the accepting edge.
	task automatic push_request(input bit cmd, input logic [6:0] row, input logic [6:0] col,
		input logic [7:0] pix, input bit typed = 1'b0, input pix_res_t typed_res = '{0, 0});
		if (!calm && $urandom_range(0, 3) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.row <= row;
		req.col <= col;
		req.pixel_in <= pix;
		do
			@(posedge clk);
		while (!req.ready);
		if (cmd == CMD_STORE) begin
			image[row*IMG + col] = pix;
			written[row*IMG + col] = 1'b1;
			n_stores++;
		end else begin
			pix_res_t r;
			r = typed ? typed_res : blend_sample(row, col);
			if (!r.in_img)
				n_outside++;
			pending_pixels.push_back(r);
			n_samples++;
		end
	endtask

	// Stores random bytes to any neighbor the sample would read that was never
	// written.
	task automatic fill_neighbors(input logic [6:0] row, input logic [6:0] col);
		src_pos_t p;
		int xs[2], ys[2];
		p = map_dest(row, col);
		if (!p.in_img)
			return;
		xs = '{p.px, p.px1};
		ys = '{p.py, p.py1};
		foreach (ys[j])
			foreach (xs[i])
				if (!written[ys[j]*IMG + xs[i]])
					push_request(CMD_STORE, 7'(ys[j]), 7'(xs[i]), 8'($urandom));
	endtask

	task automatic sample(input logic [6:0] row, input logic [6:0] col, input logic [7:0] pix,
		input bit typed = 1'b0, input pix_res_t typed_res = '{0, 0});
		fill_neighbors(row, col);
		push_request(CMD_SAMPLE, row, col, pix, typed, typed_res);
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One write per edge; cfg_we stays high across the batch.
	task automatic load_registers(input logic [31:0] vals[6], input logic [31:0] sz);
		for (int i = 0; i < 8; i++) begin
			cfg_we <= 1'b1;
			cfg_idx <= (i < 7) ? 3'(i) : REG_UNUSED;
			cfg_data <= (i < 6) ? vals[i] : (i == 6) ? sz : 32'($urandom);
			@(posedge clk);
			if (i < 6)
				mat[i] = vals[i];
			else if (i == REG_SIZE)
				size_reg = sz[7:0];
		end
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Result checker: every accepted result against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && res.valid && res.ready) begin
			if (pending_pixels.size() == 0) begin
				n_errors++;
				$display("ERROR: unexpected result pixel=%0h inside=%0b",
					res.pixel_out, res.inside_res);
			end else begin
				pix_res_t e;
				e = pending_pixels.pop_front();
				if (res.pixel_out !== e.pixel || res.inside_res !== e.in_img) begin
					n_errors++;
					n_mismatch++;
					if (n_mismatch <= 10)
						$display("ERROR: pixel %0h/%0b expected %0h/%0b", res.pixel_out,
							res.inside_res, e.pixel, e.in_img);
				end
			end
		end
	end

	// Receiver: random stall bursts, none once calm.
	initial begin
		int stall;
		stall = 0;
		res.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall > 0) begin
				stall--;
				res.ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall = $urandom_range(1, 9) - 1;
				res.ready <= 1'b0;
			end else begin
				res.ready <= 1'b1;
			end
		end
	end

	typedef struct {
		bit cmd;
		logic [6:0] row, col;
		logic [7:0] pix;
		bit typed;
		logic [7:0] epix;
		bit eins;
	} step_t;

	// Opening requests at reset registers (identity, size 112). Typed rows
	// use zero fractions, so each is just the stored pixel or an outside.
	step_t opening[] = '{
		'{CMD_STORE, 7'd0, 7'd0, 8'hFF, 0, 8'h00, 0},
		'{CMD_STORE, 7'd0, 7'd1, 8'h00, 0, 8'h00, 0},
		'{CMD_STORE, 7'd1, 7'd0, 8'h00, 0, 8'h00, 0},
		'{CMD_STORE, 7'd1, 7'd1, 8'h00, 0, 8'h00, 0},
		'{CMD_STORE, 7'd111, 7'd111, 8'h5A, 0, 8'h00, 0},
		'{CMD_STORE, 7'd127, 7'd127, 8'hAA, 0, 8'h00, 0},
		'{CMD_STORE, 7'd127, 7'd0, 8'h01, 0, 8'h00, 0},
		'{CMD_STORE, 7'd0, 7'd127, 8'h80, 0, 8'h00, 0},
		'{CMD_SAMPLE, 7'd0, 7'd0, 8'h00, 1, 8'hFF, 1},
		'{CMD_SAMPLE, 7'd0, 7'd0, 8'hFF, 1, 8'hFF, 1},    // pixel_in ignored
		'{CMD_SAMPLE, 7'd111, 7'd111, 8'h00, 1, 8'h5A, 1}, // last row/col clamp
		'{CMD_SAMPLE, 7'd112, 7'd0, 8'h00, 1, 8'h00, 0},   // dest beyond size
		'{CMD_SAMPLE, 7'd0, 7'd112, 8'h00, 1, 8'h00, 0},
		'{CMD_SAMPLE, 7'd127, 7'd127, 8'hFF, 1, 8'h00, 0},
		'{CMD_SAMPLE, 7'd1, 7'd0, 8'h33, 0, 8'h00, 0},
		'{CMD_SAMPLE, 7'd42, 7'd85, 8'h00, 0, 8'h00, 0}
	};

	initial begin
		logic [31:0] vals[6];
		logic [31:0] sz;
		int kind, sz_eff;
		logic [6:0] r, c;

		req.valid <= 1'b0;
		req.cmd <= CMD_STORE;
		req.row <= '0;
		req.col <= '0;
		req.pixel_in <= '0;
		cfg_we <= 1'b0;
		cfg_idx <= REG_COEF_XX;
		cfg_data <= '0;
		calm = 1'b0;
		mat = '{32'sd65536, 0, 0, 0, 32'sd65536, 0};
		size_reg = 8'd112;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			if (opening[i].cmd == CMD_STORE)
				push_request(CMD_STORE, opening[i].row, opening[i].col, opening[i].pix);
			else
				sample(opening[i].row, opening[i].col, opening[i].pix, opening[i].typed,
					'{opening[i].epix, opening[i].eins});
		wait_idle();

		// Phases: new registers each time, then a mix of samples and stores.
		for (int ph = 0; ph < 13; ph++) begin
			kind = (ph < 3) ? 3 : $urandom_range(0, 5);
			case (ph)
				0: sz = 32'h0000_0100;   // size zero: all outside
				1: sz = 32'hFFFF_FFC8;   // 200 saturates to 128
				2: sz = 32'd1;
				3: sz = 32'h0000_00FF;
				4: sz = 32'd128;
				default: sz = {$urandom_range(0, 1) ? 24'hFFFFFF : 24'h0,
					8'($urandom_range(2, 24))};
			endcase
			sz_eff = (sz[7:0] > IMG) ? IMG : int'(sz[7:0]);
			if (ph == 4) begin
				// register extremes: almost everything maps outside
				vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
					32'h7FFF_FFFF, 32'h7FFF_FFFF};
			end else if (kind == 0) begin
				for (int i = 0; i < 6; i++)
					vals[i] = $urandom;
			end else begin
				// near-identity, scaled or sheared, offsets keep it mostly inside
				vals[REG_COEF_XX] = 32'($urandom_range(8192, 180000));
				vals[REG_COEF_XY] = 32'(int'($urandom_range(0, 40000)) - 20000);
				vals[REG_COEF_YX] = 32'(int'($urandom_range(0, 40000)) - 20000);
				vals[REG_COEF_YY] = 32'($urandom_range(8192, 180000));
				vals[REG_OFFSET_X] = 32'(int'($urandom_range(0, sz_eff * 65536 / 2 + 65536))
					- 32768);
				vals[REG_OFFSET_Y] = 32'(int'($urandom_range(0, sz_eff * 65536 / 2 + 65536))
					- 32768);
			end
			load_registers(vals, sz);
			n_phases++;
			if (ph >= 11)
				calm = 1'b1;
			for (int k = 0; k < 85; k++) begin
				if (ph == 6 && k == 40)
					wait_idle();  // let the pipeline run dry mid-phase
				if ($urandom_range(0, 9) < 3) begin
					push_request(CMD_STORE, 7'($urandom), 7'($urandom), 8'($urandom));
				end else begin
					if (sz_eff > 0 && $urandom_range(0, 9) != 0) begin
						r = 7'($urandom_range(0, sz_eff - 1));
						c = 7'($urandom_range(0, sz_eff - 1));
					end else begin
						r = 7'($urandom);
						c = 7'($urandom);
					end
					sample(r, c, 8'($urandom));
				end
			end
			wait_idle();
		end

		if (pending_pixels.size() != 0)
			n_errors++;
		$display("Covered %0d phases of register settings: %0d samples (%0d outside),",
			n_phases, n_samples, n_outside);
		$display("%0d stores; %0d mismatches.", n_stores, n_mismatch);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
